/* rtl/core/avr_pkg.sv */
// Shared types, constants and the sine table generator for the axis-angle rotator.
// Depends on nothing; used by every module under rtl/core.
`default_nettype none

package avr_pkg;

  localparam int ANGLE_BITS_DEF     = 16;
  localparam int SINE_ADDR_BITS_DEF = 10;

  localparam int VEC_W  = 32;  // Q16.16 vector components
  localparam int AXIS_W = 16;  // Q2.14 axis components
  localparam int ANG_W  = 16;  // turn angle port width
  localparam int MAG_W  = 15;  // sine table magnitude, 0..16384
  localparam int TRIG_W = 16;  // signed sine / cosine, Q2.14
  localparam int OMC_W  = 17;  // one minus cosine, 0..32768
  localparam int AA_W   = 32;  // axis by axis product
  localparam int AOMC_W = 49;  // axis product by (1 - c)
  localparam int AS_W   = 32;  // axis by sine
  localparam int SUM_W  = 48;  // matrix entry in Q42
  localparam int MAT_W  = 30;  // matrix entry rounded to Q24
  localparam int PROD_W = 62;  // Q24 entry by Q16.16 component
  localparam int ACC_W  = 64;  // three products summed
  localparam int RND_W  = 40;  // accumulator after rounding to Q16.16

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam logic [63:0] Q14_ONE     = 64'd16384;

  // Stage 2 payload: table magnitudes, quadrant signs, axis products, vector.
  typedef struct packed {
    logic [MAG_W-1:0]         sin_mag;
    logic [MAG_W-1:0]         cos_mag;
    logic                     neg_s;
    logic                     neg_c;
    logic signed [AXIS_W-1:0] ax;
    logic signed [AXIS_W-1:0] ay;
    logic signed [AXIS_W-1:0] az;
    logic signed [AA_W-1:0]   xx;
    logic signed [AA_W-1:0]   yy;
    logic signed [AA_W-1:0]   zz;
    logic signed [AA_W-1:0]   xy;
    logic signed [AA_W-1:0]   xz;
    logic signed [AA_W-1:0]   yz;
    logic signed [VEC_W-1:0]  vx;
    logic signed [VEC_W-1:0]  vy;
    logic signed [VEC_W-1:0]  vz;
  } front_t;

  // Stage 4 payload: rotation matrix in Q24 plus the vector.
  typedef struct packed {
    logic signed [MAT_W-1:0] m00;
    logic signed [MAT_W-1:0] m01;
    logic signed [MAT_W-1:0] m02;
    logic signed [MAT_W-1:0] m10;
    logic signed [MAT_W-1:0] m11;
    logic signed [MAT_W-1:0] m12;
    logic signed [MAT_W-1:0] m20;
    logic signed [MAT_W-1:0] m21;
    logic signed [MAT_W-1:0] m22;
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
    logic signed [VEC_W-1:0] vz;
  } mat_t;

  // Quarter-wave sine entry k of a 2^addr_bits table, Q2.14. Horner Taylor
  // series in Q2.30 up to x^15; evaluated at elaboration only.
  function automatic logic [MAG_W-1:0] sine_entry(input int unsigned k,
                                                  input int unsigned addr_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    x    = (Q30_HALF_PI * 64'(k)) >> addr_bits;
    x2   = (x * x) >> 30;
    term = Q30_ONE;
    term = Q30_ONE - ((x2 * term) >> 30) / 64'd210;
    term = Q30_ONE - ((x2 * term) >> 30) / 64'd156;
    term = Q30_ONE - ((x2 * term) >> 30) / 64'd110;
    term = Q30_ONE - ((x2 * term) >> 30) / 64'd72;
    term = Q30_ONE - ((x2 * term) >> 30) / 64'd42;
    term = Q30_ONE - ((x2 * term) >> 30) / 64'd20;
    term = Q30_ONE - ((x2 * term) >> 30) / 64'd6;
    s    = (x * term) >> 30;
    s    = (s + 64'd32768) >> 16;
    if (s > Q14_ONE) begin
      s = Q14_ONE;
    end
    return s[MAG_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/avr_front.sv */
// Front stages: angle to table index (stage 1), sine ROM read and axis products (stage 2).
// Depends on avr_pkg.
`default_nettype none

module avr_front #(
  parameter int ANGLE_BITS           = avr_pkg::ANGLE_BITS_DEF,
  parameter int SINE_TABLE_ADDR_BITS = avr_pkg::SINE_ADDR_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 adv_i,
  input  wire logic                                 valid_i,
  input  wire logic signed [avr_pkg::VEC_W-1:0]     vec_x_i,
  input  wire logic signed [avr_pkg::VEC_W-1:0]     vec_y_i,
  input  wire logic signed [avr_pkg::VEC_W-1:0]     vec_z_i,
  input  wire logic signed [avr_pkg::AXIS_W-1:0]    axis_x_i,
  input  wire logic signed [avr_pkg::AXIS_W-1:0]    axis_y_i,
  input  wire logic signed [avr_pkg::AXIS_W-1:0]    axis_z_i,
  input  wire logic        [avr_pkg::ANG_W-1:0]     turn_angle_i,
  output logic                                      valid_o,
  output avr_pkg::front_t                           front_o
);
  import avr_pkg::*;

  localparam int SAB   = SINE_TABLE_ADDR_BITS;
  localparam int RW    = ANGLE_BITS - 2;
  localparam int IW    = SAB + 1;
  localparam int TBL_N = 1 << SAB;

  typedef logic [MAG_W-1:0] rom_t [TBL_N+1];

  function automatic rom_t build_rom();
    rom_t t;
    for (int k = 0; k <= TBL_N; k++) begin
      t[k] = sine_entry(k, SAB);
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Stage 1: quadrant fold of the phase for sine and cosine
  logic [ANGLE_BITS-1:0]  ph_s, ph_c;
  logic [RW+SAB-1:0]      rw_s, rw_c;
  logic [SAB-1:0]         i_s, i_c;
  logic [IW-1:0]          idx_s_d, idx_c_d;
  logic [IW-1:0]          idx_s_q, idx_c_q;
  logic                   neg_s_q, neg_c_q;
  logic signed [AXIS_W-1:0] ax1_q, ay1_q, az1_q;
  logic signed [VEC_W-1:0]  vx1_q, vy1_q, vz1_q;
  logic                   v1_q;

  always_comb begin
    ph_s = ANGLE_BITS'(turn_angle_i);
    ph_c = ph_s + ANGLE_BITS'(1 << RW);
    // shift left by the table width so that a coarse phase still indexes correctly
    rw_s = {ph_s[RW-1:0], {SAB{1'b0}}};
    rw_c = {ph_c[RW-1:0], {SAB{1'b0}}};
    i_s  = rw_s[RW +: SAB];
    i_c  = rw_c[RW +: SAB];
    idx_s_d = ph_s[RW] ? (IW'(TBL_N) - {1'b0, i_s}) : {1'b0, i_s};
    idx_c_d = ph_c[RW] ? (IW'(TBL_N) - {1'b0, i_c}) : {1'b0, i_c};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      idx_s_q <= idx_s_d;
      idx_c_q <= idx_c_d;
      neg_s_q <= ph_s[ANGLE_BITS-1];
      neg_c_q <= ph_c[ANGLE_BITS-1];
      ax1_q   <= axis_x_i;
      ay1_q   <= axis_y_i;
      az1_q   <= axis_z_i;
      vx1_q   <= vec_x_i;
      vy1_q   <= vec_y_i;
      vz1_q   <= vec_z_i;
    end
  end

  // Stage 2: two ROM reads and the six distinct axis products
  front_t front_q;
  logic   v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      front_q.sin_mag <= SINE_ROM[idx_s_q];
      front_q.cos_mag <= SINE_ROM[idx_c_q];
      front_q.neg_s   <= neg_s_q;
      front_q.neg_c   <= neg_c_q;
      front_q.ax      <= ax1_q;
      front_q.ay      <= ay1_q;
      front_q.az      <= az1_q;
      front_q.xx      <= ax1_q * ax1_q;
      front_q.yy      <= ay1_q * ay1_q;
      front_q.zz      <= az1_q * az1_q;
      front_q.xy      <= ax1_q * ay1_q;
      front_q.xz      <= ax1_q * az1_q;
      front_q.yz      <= ay1_q * az1_q;
      front_q.vx      <= vx1_q;
      front_q.vy      <= vy1_q;
      front_q.vz      <= vz1_q;
    end
  end

  assign valid_o = v2_q;
  assign front_o = front_q;

endmodule

`default_nettype wire

/* rtl/core/avr_matrix.sv */
// Matrix stages: products with sine and 1 - cosine (stage 3), Q24 entries (stage 4).
// Depends on avr_pkg.
`default_nettype none

module avr_matrix (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            adv_i,
  input  wire logic            valid_i,
  input  wire avr_pkg::front_t front_i,
  output logic                 valid_o,
  output avr_pkg::mat_t        mat_o
);
  import avr_pkg::*;

  logic signed [TRIG_W-1:0] sin_d, cos_d;
  logic signed [OMC_W-1:0]  omc_d;

  always_comb begin
    sin_d = front_i.neg_s ? -$signed({1'b0, front_i.sin_mag}) : $signed({1'b0, front_i.sin_mag});
    cos_d = front_i.neg_c ? -$signed({1'b0, front_i.cos_mag}) : $signed({1'b0, front_i.cos_mag});
    omc_d = OMC_W'(Q14_ONE) - OMC_W'(cos_d);
  end

  // Stage 3
  logic signed [AOMC_W-1:0] pxx_q, pyy_q, pzz_q, pxy_q, pxz_q, pyz_q;
  logic signed [AS_W-1:0]   xs_q, ys_q, zs_q;
  logic signed [TRIG_W-1:0] c3_q;
  logic signed [VEC_W-1:0]  vx3_q, vy3_q, vz3_q;
  logic                     v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v3_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pxx_q <= front_i.xx * omc_d;
      pyy_q <= front_i.yy * omc_d;
      pzz_q <= front_i.zz * omc_d;
      pxy_q <= front_i.xy * omc_d;
      pxz_q <= front_i.xz * omc_d;
      pyz_q <= front_i.yz * omc_d;
      xs_q  <= front_i.ax * sin_d;
      ys_q  <= front_i.ay * sin_d;
      zs_q  <= front_i.az * sin_d;
      c3_q  <= cos_d;
      vx3_q <= front_i.vx;
      vy3_q <= front_i.vy;
      vz3_q <= front_i.vz;
    end
  end

  // Stage 4: entries in Q42, then round half up to Q24
  logic signed [SUM_W-1:0] c42, xs42, ys42, zs42;
  logic signed [SUM_W-1:0] s00, s01, s02, s10, s11, s12, s20, s21, s22;
  logic signed [SUM_W-1:0] rnd;
  mat_t mat_d, mat_q;
  logic v4_q;

  always_comb begin
    c42  = SUM_W'(c3_q) <<< 28;
    xs42 = SUM_W'(xs_q) <<< 14;
    ys42 = SUM_W'(ys_q) <<< 14;
    zs42 = SUM_W'(zs_q) <<< 14;
    rnd  = SUM_W'(1) <<< 17;
    s00  = c42 + SUM_W'(pxx_q) + rnd;
    s01  = SUM_W'(pxy_q) - zs42 + rnd;
    s02  = SUM_W'(pxz_q) + ys42 + rnd;
    s10  = SUM_W'(pxy_q) + zs42 + rnd;
    s11  = c42 + SUM_W'(pyy_q) + rnd;
    s12  = SUM_W'(pyz_q) - xs42 + rnd;
    s20  = SUM_W'(pxz_q) - ys42 + rnd;
    s21  = SUM_W'(pyz_q) + xs42 + rnd;
    s22  = c42 + SUM_W'(pzz_q) + rnd;
    mat_d.m00 = s00[MAT_W+17:18];
    mat_d.m01 = s01[MAT_W+17:18];
    mat_d.m02 = s02[MAT_W+17:18];
    mat_d.m10 = s10[MAT_W+17:18];
    mat_d.m11 = s11[MAT_W+17:18];
    mat_d.m12 = s12[MAT_W+17:18];
    mat_d.m20 = s20[MAT_W+17:18];
    mat_d.m21 = s21[MAT_W+17:18];
    mat_d.m22 = s22[MAT_W+17:18];
    mat_d.vx  = vx3_q;
    mat_d.vy  = vy3_q;
    mat_d.vz  = vz3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mat_q <= mat_d;
    end
  end

  assign valid_o = v4_q;
  assign mat_o   = mat_q;

endmodule

`default_nettype wire

/* rtl/core/avr_mac.sv */
// Matrix-vector stages: nine products (stage 5), sum, round and saturate (stage 6).
// Depends on avr_pkg.
`default_nettype none

module avr_mac (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             adv_i,
  input  wire logic                             valid_i,
  input  wire avr_pkg::mat_t                    mat_i,
  output logic                                  valid_o,
  output logic signed [avr_pkg::VEC_W-1:0]      rot_x_o,
  output logic signed [avr_pkg::VEC_W-1:0]      rot_y_o,
  output logic signed [avr_pkg::VEC_W-1:0]      rot_z_o,
  output logic                                  clipped_o
);
  import avr_pkg::*;

  // Stage 5
  logic signed [PROD_W-1:0] p00_q, p01_q, p02_q, p10_q, p11_q, p12_q, p20_q, p21_q, p22_q;
  logic v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv_i) begin
      v5_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p00_q <= mat_i.m00 * mat_i.vx;
      p01_q <= mat_i.m01 * mat_i.vy;
      p02_q <= mat_i.m02 * mat_i.vz;
      p10_q <= mat_i.m10 * mat_i.vx;
      p11_q <= mat_i.m11 * mat_i.vy;
      p12_q <= mat_i.m12 * mat_i.vz;
      p20_q <= mat_i.m20 * mat_i.vx;
      p21_q <= mat_i.m21 * mat_i.vy;
      p22_q <= mat_i.m22 * mat_i.vz;
    end
  end

  // Stage 6: Q40 sum, round half up to Q16.16, clamp to 32 bits
  logic signed [ACC_W-1:0] acc_x, acc_y, acc_z;
  logic signed [RND_W-1:0] r_x, r_y, r_z;
  logic                    ov_x, ov_y, ov_z;
  logic signed [VEC_W-1:0] rot_x_d, rot_y_d, rot_z_d;
  logic signed [VEC_W-1:0] rot_x_q, rot_y_q, rot_z_q;
  logic                    clip_q;
  logic                    v6_q;

  function automatic logic signed [VEC_W-1:0] clamp(input logic signed [RND_W-1:0] r);
    logic ov;
    ov = (r[RND_W-1:VEC_W-1] != '0) && (r[RND_W-1:VEC_W-1] != '1);
    if (!ov) begin
      return r[VEC_W-1:0];
    end
    return r[RND_W-1] ? {1'b1, {(VEC_W-1){1'b0}}} : {1'b0, {(VEC_W-1){1'b1}}};
  endfunction

  always_comb begin
    acc_x = ACC_W'(p00_q) + ACC_W'(p01_q) + ACC_W'(p02_q) + (ACC_W'(1) <<< 23);
    acc_y = ACC_W'(p10_q) + ACC_W'(p11_q) + ACC_W'(p12_q) + (ACC_W'(1) <<< 23);
    acc_z = ACC_W'(p20_q) + ACC_W'(p21_q) + ACC_W'(p22_q) + (ACC_W'(1) <<< 23);
    r_x   = acc_x[ACC_W-1:24];
    r_y   = acc_y[ACC_W-1:24];
    r_z   = acc_z[ACC_W-1:24];
    ov_x  = (r_x[RND_W-1:VEC_W-1] != '0) && (r_x[RND_W-1:VEC_W-1] != '1);
    ov_y  = (r_y[RND_W-1:VEC_W-1] != '0) && (r_y[RND_W-1:VEC_W-1] != '1);
    ov_z  = (r_z[RND_W-1:VEC_W-1] != '0) && (r_z[RND_W-1:VEC_W-1] != '1);
    rot_x_d = clamp(r_x);
    rot_y_d = clamp(r_y);
    rot_z_d = clamp(r_z);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (adv_i) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rot_x_q <= rot_x_d;
      rot_y_q <= rot_y_d;
      rot_z_q <= rot_z_d;
      clip_q  <= ov_x | ov_y | ov_z;
    end
  end

  assign valid_o   = v6_q;
  assign rot_x_o   = rot_x_q;
  assign rot_y_o   = rot_y_q;
  assign rot_z_o   = rot_z_q;
  assign clipped_o = clip_q;

endmodule

`default_nettype wire

/* rtl/core/axis_angle_vector_rotation.sv */
// Axis-angle (Rodrigues) vector rotation, top level. Each accepted item passes through six
// register stages to its result on the output register.
// Throughput: one item per cycle; six items in flight; the whole pipeline freezes while
// a result is stalled. The dual-port sine ROM gives sine and cosine in the same stage.
// Reset clears only the stage valid bits; no clearing pass is needed.
// Depends on avr_pkg, avr_front, avr_matrix, avr_mac.
`default_nettype none

module axis_angle_vector_rotation #(
  parameter int ANGLE_BITS           = avr_pkg::ANGLE_BITS_DEF,
  parameter int SINE_TABLE_ADDR_BITS = avr_pkg::SINE_ADDR_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [avr_pkg::VEC_W-1:0]  vec_x_i,
  input  wire logic signed [avr_pkg::VEC_W-1:0]  vec_y_i,
  input  wire logic signed [avr_pkg::VEC_W-1:0]  vec_z_i,
  input  wire logic signed [avr_pkg::AXIS_W-1:0] axis_x_i,
  input  wire logic signed [avr_pkg::AXIS_W-1:0] axis_y_i,
  input  wire logic signed [avr_pkg::AXIS_W-1:0] axis_z_i,
  input  wire logic        [avr_pkg::ANG_W-1:0]  turn_angle_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [avr_pkg::VEC_W-1:0]       rot_x_o,
  output logic signed [avr_pkg::VEC_W-1:0]       rot_y_o,
  output logic signed [avr_pkg::VEC_W-1:0]       rot_z_o,
  output logic                                   clipped_o
);
  import avr_pkg::*;

  logic   adv;
  logic   front_valid, mat_valid;
  front_t front;
  mat_t   mat;

  // whole pipeline moves unless a finished item is held at the output
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  avr_front #(
    .ANGLE_BITS           (ANGLE_BITS),
    .SINE_TABLE_ADDR_BITS (SINE_TABLE_ADDR_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .valid_i      (in_valid_i),
    .vec_x_i      (vec_x_i),
    .vec_y_i      (vec_y_i),
    .vec_z_i      (vec_z_i),
    .axis_x_i     (axis_x_i),
    .axis_y_i     (axis_y_i),
    .axis_z_i     (axis_z_i),
    .turn_angle_i (turn_angle_i),
    .valid_o      (front_valid),
    .front_o      (front)
  );

  avr_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (front_valid),
    .front_i (front),
    .valid_o (mat_valid),
    .mat_o   (mat)
  );

  avr_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (mat_valid),
    .mat_i     (mat),
    .valid_o   (out_valid_o),
    .rot_x_o   (rot_x_o),
    .rot_y_o   (rot_y_o),
    .rot_z_o   (rot_z_o),
    .clipped_o (clipped_o)
  );

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for axis_angle_vector_rotation: random and directed rotations,
// predicted in place with a fixed-point Rodrigues model and its own quarter-wave sine table.
// Depends on avr_pkg and the rtl/core sources.
`timescale 1ns / 100ps

module testbench;

  import avr_pkg::*;

  localparam int           TBL_BITS  = 10;
  localparam int           TBL_SIZE  = 1 << TBL_BITS;
  localparam longint       SAT_HI    = 64'sd2147483647;
  localparam longint       SAT_LO    = -64'sd2147483648;
  localparam longint       AXIS_ONE  = 64'sd16384;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int           N_RANDOM  = 900;
  localparam int           HOLD_LEN  = 120;
  localparam int           CYC_LIMIT = 200000;

  typedef struct packed {
    logic signed [VEC_W-1:0]  vx;
    logic signed [VEC_W-1:0]  vy;
    logic signed [VEC_W-1:0]  vz;
    logic signed [AXIS_W-1:0] ax;
    logic signed [AXIS_W-1:0] ay;
    logic signed [AXIS_W-1:0] az;
    logic [ANG_W-1:0]         ang;
  } item_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] rx;
    logic signed [VEC_W-1:0] ry;
    logic signed [VEC_W-1:0] rz;
    logic                    clip;
  } rot_t;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_stall_o;
  logic signed [VEC_W-1:0]  vec_x_i      = '0;
  logic signed [VEC_W-1:0]  vec_y_i      = '0;
  logic signed [VEC_W-1:0]  vec_z_i      = '0;
  logic signed [AXIS_W-1:0] axis_x_i     = '0;
  logic signed [AXIS_W-1:0] axis_y_i     = '0;
  logic signed [AXIS_W-1:0] axis_z_i     = '0;
  logic [ANG_W-1:0]         turn_angle_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i  = 1'b0;
  logic signed [VEC_W-1:0]  rot_x_o;
  logic signed [VEC_W-1:0]  rot_y_o;
  logic signed [VEC_W-1:0]  rot_z_o;
  logic                     clipped_o;

  item_t  vec_items [$];   // items still to be offered
  rot_t   rotated_q [$];   // predicted rotations awaiting the block
  longint sine_tbl [0:TBL_SIZE];
  item_t  drv_item;
  rot_t   want_rot;
  logic   in_taken    = 1'b0;
  int     hold_cycles = 0;
  logic   hold_done   = 1'b0;
  int     n_taken     = 0;
  int     n_checked   = 0;
  int     n_clip      = 0;
  int     n_directed  = 0;
  int     errors      = 0;
  int     cyc         = 0;
  logic   calm;

  axis_angle_vector_rotation dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .vec_x_i      (vec_x_i),
    .vec_y_i      (vec_y_i),
    .vec_z_i      (vec_z_i),
    .axis_x_i     (axis_x_i),
    .axis_y_i     (axis_y_i),
    .axis_z_i     (axis_z_i),
    .turn_angle_i (turn_angle_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .rot_x_o      (rot_x_o),
    .rot_y_o      (rot_y_o),
    .rot_z_o      (rot_z_o),
    .clipped_o    (clipped_o)
  );

  always #6 clk_i = ~clk_i;

  // no idling on either side in this window
  assign calm = (n_taken >= 500) && (n_taken < 700);

  // Quarter-wave sine in Q2.14 from a truncating Q2.30 Taylor series.
  function automatic longint quarter_sine(int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned s;
    longint unsigned d;
    x    = (HALF_PI_Q30 * 64'(k)) >> TBL_BITS;
    x2   = (x * x) >> 30;
    term = ONE_Q30;
    for (int m = 7; m >= 1; m--) begin
      d    = 64'(2 * m) * 64'(2 * m + 1);
      term = ONE_Q30 - ((x2 * term) >> 30) / d;
    end
    s = (x * term) >> 30;
    s = (s + 64'd32768) >> 16;
    if (s > 64'd16384) begin
      s = 64'd16384;
    end
    return longint'(s);
  endfunction

  function automatic longint sine_at(logic [ANG_W-1:0] ph);
    int unsigned idx;
    longint      mag;
    idx = 32'(ph[ANG_W-3 -: TBL_BITS]);
    mag = ph[ANG_W-2] ? sine_tbl[TBL_SIZE - idx] : sine_tbl[idx];
    return ph[ANG_W-1] ? -mag : mag;
  endfunction

  // round half up: floor((v + 2^(n-1)) / 2^n)
  function automatic longint round_up_shift(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic rot_t predict_rotation(item_t it);
    longint ax, ay, az, s, c, omc, c42, xs, ys, zs, acc, r;
    longint vv [3];
    longint mm [3][3];
    logic [VEC_W-1:0] outv [3];
    logic clip;
    rot_t res;
    ax  = longint'($signed(it.ax));
    ay  = longint'($signed(it.ay));
    az  = longint'($signed(it.az));
    s   = sine_at(it.ang);
    c   = sine_at(it.ang + 16'h4000);
    omc = AXIS_ONE - c;
    c42 = c * (longint'(1) <<< 28);
    xs  = ax * s * AXIS_ONE;
    ys  = ay * s * AXIS_ONE;
    zs  = az * s * AXIS_ONE;
    vv[0] = longint'($signed(it.vx));
    vv[1] = longint'($signed(it.vy));
    vv[2] = longint'($signed(it.vz));
    mm[0][0] = c42 + ax * ax * omc;
    mm[0][1] = ax * ay * omc - zs;
    mm[0][2] = ax * az * omc + ys;
    mm[1][0] = ay * ax * omc + zs;
    mm[1][1] = c42 + ay * ay * omc;
    mm[1][2] = ay * az * omc - xs;
    mm[2][0] = az * ax * omc - ys;
    mm[2][1] = az * ay * omc + xs;
    mm[2][2] = c42 + az * az * omc;
    clip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        acc += round_up_shift(mm[i][j], 18) * vv[j];
      end
      r = round_up_shift(acc, 24);
      if (r > SAT_HI) begin
        r    = SAT_HI;
        clip = 1'b1;
      end else if (r < SAT_LO) begin
        r    = SAT_LO;
        clip = 1'b1;
      end
      outv[i] = r[VEC_W-1:0];
    end
    res.rx   = outv[0];
    res.ry   = outv[1];
    res.rz   = outv[2];
    res.clip = clip;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH result %0d %s: got %h expected %h", n_checked, what, got, want);
    errors++;
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  task automatic add_item(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                          logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                          logic [15:0] ang);
    item_t it;
    it.vx  = vx;
    it.vy  = vy;
    it.vz  = vz;
    it.ax  = ax;
    it.ay  = ay;
    it.az  = az;
    it.ang = ang;
    vec_items.push_back(it);
  endtask

  // Sender: a held item only moves on once taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (vec_items.size() != 0 && (calm || $urandom_range(0, 99) >= 34)) begin
        drv_item = vec_items.pop_front();
        in_valid_i   <= 1'b1;
        vec_x_i      <= drv_item.vx;
        vec_y_i      <= drv_item.vy;
        vec_z_i      <= drv_item.vz;
        axis_x_i     <= drv_item.ax;
        axis_y_i     <= drv_item.ay;
        axis_z_i     <= drv_item.az;
        turn_angle_i <= drv_item.ang;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Long receiver hold-off once, so the pipeline fills and backs up the input.
  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (!hold_done && n_taken >= 300) begin
      hold_cycles <= HOLD_LEN;
      hold_done   <= 1'b1;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= (hold_cycles != 0) || (!calm && $urandom_range(0, 99) < 34);
  end

  // Check results, then predict for the item taken at this edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rotated_q.size() == 0) begin
        report_mismatch("result with nothing expected", rot_x_o, 32'h0);
      end else begin
        want_rot = rotated_q.pop_front();
        check_field("rot_x", rot_x_o, want_rot.rx);
        check_field("rot_y", rot_y_o, want_rot.ry);
        check_field("rot_z", rot_z_o, want_rot.rz);
        check_field("clipped", {31'd0, clipped_o}, {31'd0, want_rot.clip});
      end
      n_checked++;
    end
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      rotated_q.push_back(predict_rotation({vec_x_i, vec_y_i, vec_z_i, axis_x_i, axis_y_i,
                                            axis_z_i, turn_angle_i}));
      if (rotated_q[$].clip) begin
        n_clip++;
      end
      n_taken++;
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == CYC_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected", cyc, rotated_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] vx, vy, vz;
    logic [15:0] ax, ay, az, ang;
    logic [31:0] corner [5];
    logic [15:0] spec_ang [6];
    real fx, fy, fz, len;
    int kind, j;
    corner   = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h1};
    spec_ang = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'hffff, 16'h3fff};
    for (int k = 0; k <= TBL_SIZE; k++) begin
      sine_tbl[k] = quarter_sine(k);
    end

    // directed: identity, quarter turns about each axis, quadrant edges,
    // saturation both ways, non-unit and zero axes, truncated phase bits
    add_item(32'h0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd16384, 16'h0000);
    add_item(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'd0, 16'd0, 16'd16384, 16'h0000);
    add_item(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'd0, 16'd0, 16'd16384, 16'h0000);
    add_item(32'h0001_0000, 32'h0, 32'h0, 16'd0, 16'd0, 16'd16384, 16'h4000);
    add_item(32'h0001_0000, 32'h0, 32'h0, 16'd0, 16'd0, 16'd16384, 16'h8000);
    add_item(32'h0001_0000, 32'h0, 32'h0, 16'd0, 16'd0, 16'd16384, 16'hc000);
    add_item(32'h0001_0000, 32'h0, 32'h0, 16'd0, 16'd0, 16'd16384, 16'hffff);
    add_item(32'h0001_0000, 32'h0, 32'h0, 16'd0, 16'd0, 16'd16384, 16'h2000);
    add_item(32'h0, 32'h0001_0000, 32'h0, 16'd16384, 16'd0, 16'd0, 16'h4000);
    add_item(32'h0, 32'h0, 32'h0001_0000, 16'd0, 16'd16384, 16'd0, 16'h4000);
    add_item(32'h0001_0000, 32'h0, 32'h0, 16'd0, 16'd0, 16'hc000, 16'h4000);
    add_item(32'h0001_0000, 32'h0, 32'h0, 16'd0, 16'd0, 16'd16384, 16'h3fff);
    add_item(32'h0001_0000, 32'h0, 32'h0, 16'd0, 16'd0, 16'd16384, 16'h000f);
    add_item(32'h0001_0000, 32'h0, 32'h0, 16'd0, 16'd0, 16'd16384, 16'h0010);
    add_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'd0, 16'd0, 16'd16384, 16'h2000);
    add_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'd0, 16'd0, 16'hc000, 16'h6000);
    add_item(32'h0100_0000, 32'h0200_0000, 32'hff00_0000, 16'h8000, 16'h8000, 16'h8000,
             16'h8000);
    add_item(32'h7fff_ffff, 32'h8000_0000, 32'h0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h4000);
    add_item(32'h0005_0000, 32'hfffb_0000, 32'h0003_0000, 16'd0, 16'd0, 16'd0, 16'h4000);
    add_item(32'h0001_0000, 32'h0, 32'h0, 16'd9459, 16'd9459, 16'd9459, 16'h5555);
    add_item(32'hffff_ffff, 32'h1, 32'h8000_0000, 16'd16384, 16'd0, 16'd0, 16'hc000);
    n_directed = vec_items.size();

    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        vx = int'($urandom_range(0, 1 << 23)) - (1 << 22);
        vy = int'($urandom_range(0, 1 << 23)) - (1 << 22);
        vz = int'($urandom_range(0, 1 << 23)) - (1 << 22);
      end else if (kind < 85) begin
        vx = $urandom;
        vy = $urandom;
        vz = $urandom;
      end else begin
        vx = corner[$urandom_range(0, 4)];
        vy = corner[$urandom_range(0, 4)];
        vz = corner[$urandom_range(0, 4)];
      end
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        fx  = real'(int'($urandom_range(0, 32768)) - 16384);
        fy  = real'(int'($urandom_range(0, 32768)) - 16384);
        fz  = real'(int'($urandom_range(0, 32768)) - 16384);
        len = $sqrt(fx * fx + fy * fy + fz * fz);
        if (len < 1.0) begin
          fz  = 1.0;
          len = 1.0;
        end
        ax = 16'(int'(fx / len * 16384.0));
        ay = 16'(int'(fy / len * 16384.0));
        az = 16'(int'(fz / len * 16384.0));
      end else if (kind < 80) begin
        j  = $urandom_range(0, 2);
        ax = (j == 0) ? 16'd16384 : 16'd0;
        ay = (j == 1) ? 16'd16384 : 16'd0;
        az = (j == 2) ? 16'd16384 : 16'd0;
        if ($urandom_range(0, 1) == 1) begin
          ax = -ax;
          ay = -ay;
          az = -az;
        end
      end else begin
        ax = 16'($urandom);
        ay = 16'($urandom);
        az = 16'($urandom);
      end
      ang = ($urandom_range(0, 99) < 85) ? 16'($urandom) : spec_ang[$urandom_range(0, 5)];
      add_item(vx, vy, vz, ax, ay, az, ang);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (vec_items.size() == 0 && !in_valid_i && rotated_q.size() == 0);
    repeat (12) @(posedge clk_i);

    $display("Rotated %0d vectors (%0d directed, %0d clipped), %0d results checked",
             n_taken, n_directed, n_clip, n_checked);
    $display("Random idling on both sides, one %0d-cycle receiver hold-off, %0d mismatches",
             HOLD_LEN, errors);
    if (errors == 0 && rotated_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
